### hw/rtl/dfpc_pkg.sv
// shared types and constants for the dag frontier path counter
package dfpc_pkg;

	localparam int INDEX_W = 13;
	localparam int VALUE_W = 14;
	localparam int PATH_W = 32;
	localparam int TOTAL_W = 11;
	localparam int VCOUNT_W = 11;
	localparam int FIFO_DEPTH = 4;

	typedef enum logic [1:0] {
		OP_ROW  = 2'd0,
		OP_EDGE = 2'd1,
		OP_RUN  = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [INDEX_W-1:0]   index;
		logic [VALUE_W-1:0]   value;
		logic                 bad;
	} cmd_t;

endpackage

### hw/rtl/dfpc_front.sv
// input stage: accepts items, checks ranges and registers a decoded command
module dfpc_front #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES = 8192,
	parameter int NW = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [NW-1:0]                 n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  dfpc_pkg::op_t                 in_op,
	input  logic [dfpc_pkg::INDEX_W-1:0]  in_index,
	input  logic [dfpc_pkg::VALUE_W-1:0]  in_value,
	output logic                          cmd_valid,
	input  logic                          cmd_ready,
	output dfpc_pkg::cmd_t                cmd
);

	logic           valid_s1;
	dfpc_pkg::cmd_t cmd_s1;
	logic           bad;

	always_comb begin
		case (in_op)
			dfpc_pkg::OP_ROW:  bad = (32'(in_index) > MAX_VERTICES) ||
				(32'(in_value) > MAX_EDGES);
			dfpc_pkg::OP_EDGE: bad = (32'(in_index) >= MAX_EDGES) ||
				(32'(in_value) >= MAX_VERTICES);
			dfpc_pkg::OP_READ: bad = (32'(in_index) >= 32'(n));
			default:           bad = 1'b0;
		endcase
	end

	assign in_ready = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1.op <= in_op;
			cmd_s1.index <= in_index;
			cmd_s1.value <= in_value;
			cmd_s1.bad <= bad;
		end
	end

endmodule

### hw/rtl/dfpc_cmd_fifo.sv
// short command queue between the input stage and the engine
module dfpc_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  dfpc_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           empty,
	output dfpc_pkg::cmd_t pop_cmd
);

	localparam int PW = $clog2(dfpc_pkg::FIFO_DEPTH);

	dfpc_pkg::cmd_t       slot_q [dfpc_pkg::FIFO_DEPTH];
	logic [PW-1:0]        wr_q;
	logic [PW-1:0]        rd_q;
	logic [PW:0]          count_q;

	assign full = (count_q == (PW+1)'(dfpc_pkg::FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign pop_cmd = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= rd_q + 1'b1;
			end
			if ((push && !full) && !(pop && !empty)) begin
				count_q <= count_q + 1'b1;
			end else if (!(push && !full) && (pop && !empty)) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

endmodule

### hw/rtl/dfpc_engine.sv
// back end: graph stores, run sequencer and result register
module dfpc_engine #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES = 8192,
	parameter int NW = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [NW-1:0]                 n,
	input  logic                          cmd_valid,
	output logic                          cmd_pop,
	input  dfpc_pkg::cmd_t                cmd,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dfpc_pkg::PATH_W-1:0]   path_count,
	output logic [dfpc_pkg::TOTAL_W-1:0]  processed_count,
	output logic [dfpc_pkg::TOTAL_W-1:0]  level_count,
	output logic                          all_reached,
	output logic                          bad_access
);

	localparam int VAW = $clog2(MAX_VERTICES);
	localparam int RAW = $clog2(MAX_VERTICES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int RW = $clog2(MAX_EDGES + 1);
	localparam int DW = VAW + RW + 1;
	localparam int FAW = VAW + 1;
	localparam int PW = dfpc_pkg::PATH_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLR, ST_DROW, ST_DROW_W, ST_DEDGE, ST_DEDGE_W, ST_DINC,
		ST_SEED, ST_SEED_W, ST_LVL, ST_LW, ST_LW2, ST_LE, ST_LE_W, ST_LUPD, ST_FIN
	} state_t;

	logic [RW-1:0]  rs_mem [MAX_VERTICES+1];
	logic [VAW-1:0] edge_mem [MAX_EDGES];
	logic [DW-1:0]  deg_mem [MAX_VERTICES];
	logic [PW-1:0]  val_mem [MAX_VERTICES];
	logic [VAW-1:0] fr_mem [2*MAX_VERTICES];

	state_t         state_q;
	logic [NW-1:0]  cnt_q, csize_q, nsize_q, total_q, levels_q;
	logic [RW-1:0]  e_q, hi_q;
	logic [VAW-1:0] v_q;
	logic [PW-1:0]  wval_q;
	logic           bank_q, ran_q;
	logic [NW-1:0]  run_proc_q, run_lvl_q;
	logic           run_reached_q;
	logic           s1_valid;
	dfpc_pkg::cmd_t s1_cmd;

	logic [RW-1:0]  rsa_d, rsb_d;
	logic [VAW-1:0] edge_d, fr_d;
	logic [DW-1:0]  deg_d;
	logic [PW-1:0]  val_d;

	logic           rs_we, rs_re, e_we, e_re, deg_we, deg_re, v_we, v_re, fr_we, fr_re;
	logic [RAW-1:0] rs_wa, rs_ra, rs_rb;
	logic [RW-1:0]  rs_wd;
	logic [EAW-1:0] e_wa, e_ra;
	logic [VAW-1:0] e_wd, deg_wa, deg_ra, v_wa, v_ra, fr_wd;
	logic [DW-1:0]  deg_wd;
	logic [PW-1:0]  v_wd;
	logic [FAW-1:0] fr_wa, fr_ra;

	logic           adv;
	logic           s1_load;
	logic [RW-1:0]  lo, hi;
	logic [PW:0]    sum;
	logic [PW-1:0]  sat;
	logic           v_in;

	assign adv = !out_valid || out_ready;
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid && (!s1_valid || adv);
	assign s1_load = (cmd_pop && cmd.op != dfpc_pkg::OP_RUN) || (state_q == ST_FIN);
	assign hi = (rsb_d > RW'(MAX_EDGES)) ? RW'(MAX_EDGES) : rsb_d;
	assign lo = (rsa_d > hi) ? hi : rsa_d;
	assign sum = {1'b0, val_d} + {1'b0, wval_q};
	assign sat = sum[PW] ? '1 : sum[PW-1:0];
	assign v_in = ({1'b0, edge_d} < NW'(n));

	always_comb begin
		rs_we = 1'b0; rs_re = 1'b0; e_we = 1'b0; e_re = 1'b0;
		deg_we = 1'b0; deg_re = 1'b0; v_we = 1'b0; v_re = 1'b0;
		fr_we = 1'b0; fr_re = 1'b0;
		rs_wa = RAW'(cmd.index); rs_wd = RW'(cmd.value);
		rs_ra = RAW'(cnt_q); rs_rb = RAW'(cnt_q + 1'b1);
		e_wa = EAW'(cmd.index); e_wd = VAW'(cmd.value); e_ra = EAW'(e_q);
		deg_wa = v_q; deg_wd = deg_d + 1'b1; deg_ra = edge_d;
		v_wa = v_q; v_wd = sat; v_ra = edge_d;
		fr_wa = {~bank_q, nsize_q[VAW-1:0]}; fr_wd = v_q;
		fr_ra = {bank_q, cnt_q[VAW-1:0]};
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_pop) begin
					case (cmd.op)
						dfpc_pkg::OP_ROW:  rs_we = !cmd.bad;
						dfpc_pkg::OP_EDGE: e_we = !cmd.bad;
						dfpc_pkg::OP_READ: begin
							v_re = 1'b1;
							v_ra = VAW'(cmd.index);
						end
						default: ;
					endcase
				end
			end
			ST_CLR: begin
				deg_we = 1'b1; deg_wa = cnt_q[VAW-1:0]; deg_wd = '0;
				v_we = 1'b1; v_wa = cnt_q[VAW-1:0]; v_wd = '0;
			end
			ST_DROW: rs_re = (cnt_q != n);
			ST_DEDGE, ST_LE: e_re = (e_q < hi_q);
			ST_DEDGE_W: deg_re = v_in;
			ST_DINC: deg_we = 1'b1;
			ST_SEED: begin
				deg_re = (cnt_q != n);
				deg_ra = cnt_q[VAW-1:0];
			end
			ST_SEED_W: begin
				if (deg_d == '0) begin
					v_we = 1'b1; v_wa = cnt_q[VAW-1:0]; v_wd = PW'(1);
					fr_we = 1'b1; fr_wa = {bank_q, csize_q[VAW-1:0]};
					fr_wd = cnt_q[VAW-1:0];
				end
			end
			ST_LVL: fr_re = (csize_q != '0) && (cnt_q != csize_q);
			ST_LW: begin
				v_re = 1'b1; v_ra = fr_d;
				rs_re = 1'b1; rs_ra = RAW'(fr_d);
				rs_rb = RAW'({1'b0, fr_d} + 1'b1);
			end
			ST_LE_W: begin
				v_re = v_in;
				deg_re = v_in;
			end
			ST_LUPD: begin
				v_we = 1'b1;
				if (deg_d != '0) begin
					deg_we = 1'b1;
					deg_wd = deg_d - 1'b1;
					fr_we = (deg_d == DW'(1));
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rs_we) begin
			rs_mem[rs_wa] <= rs_wd;
		end
		if (rs_re) begin
			rsa_d <= rs_mem[rs_ra];
			rsb_d <= rs_mem[rs_rb];
		end
	end

	always_ff @(posedge clk) begin
		if (e_we) begin
			edge_mem[e_wa] <= e_wd;
		end
		if (e_re) begin
			edge_d <= edge_mem[e_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[deg_wa] <= deg_wd;
		end
		if (deg_re) begin
			deg_d <= deg_mem[deg_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (v_we) begin
			val_mem[v_wa] <= v_wd;
		end
		if (v_re) begin
			val_d <= val_mem[v_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (fr_we) begin
			fr_mem[fr_wa] <= fr_wd;
		end
		if (fr_re) begin
			fr_d <= fr_mem[fr_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0; csize_q <= '0; nsize_q <= '0; total_q <= '0; levels_q <= '0;
			e_q <= '0; hi_q <= '0; v_q <= '0; wval_q <= '0; bank_q <= 1'b0;
			ran_q <= 1'b0;
			run_proc_q <= '0; run_lvl_q <= '0; run_reached_q <= 1'b0;
			s1_valid <= 1'b0; s1_cmd <= '0;
			out_valid <= 1'b0; path_count <= '0; processed_count <= '0;
			level_count <= '0; all_reached <= 1'b0; bad_access <= 1'b0;
		end else begin
			if (adv) begin
				out_valid <= s1_valid;
				path_count <= (s1_cmd.op == dfpc_pkg::OP_READ && !s1_cmd.bad && ran_q) ?
					val_d : '0;
				processed_count <= dfpc_pkg::TOTAL_W'(run_proc_q);
				level_count <= dfpc_pkg::TOTAL_W'(run_lvl_q);
				all_reached <= run_reached_q;
				bad_access <= s1_cmd.bad;
			end
			if (s1_load) begin
				s1_valid <= 1'b1;
			end else if (adv) begin
				s1_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						if (cmd.op == dfpc_pkg::OP_RUN) begin
							state_q <= ST_CLR;
							cnt_q <= '0;
						end else begin
							s1_cmd <= cmd;
						end
					end
				end
				ST_CLR: begin
					if (cnt_q == NW'(MAX_VERTICES - 1)) begin
						cnt_q <= '0;
						state_q <= ST_DROW;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DROW: begin
					if (cnt_q == n) begin
						cnt_q <= '0;
						csize_q <= '0;
						bank_q <= 1'b0;
						state_q <= ST_SEED;
					end else begin
						state_q <= ST_DROW_W;
					end
				end
				ST_DROW_W: begin
					e_q <= lo;
					hi_q <= hi;
					state_q <= ST_DEDGE;
				end
				ST_DEDGE: begin
					if (e_q < hi_q) begin
						state_q <= ST_DEDGE_W;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= ST_DROW;
					end
				end
				ST_DEDGE_W: begin
					v_q <= edge_d;
					if (v_in) begin
						state_q <= ST_DINC;
					end else begin
						e_q <= e_q + 1'b1;
						state_q <= ST_DEDGE;
					end
				end
				ST_DINC: begin
					e_q <= e_q + 1'b1;
					state_q <= ST_DEDGE;
				end
				ST_SEED: begin
					if (cnt_q == n) begin
						cnt_q <= '0;
						total_q <= csize_q;
						nsize_q <= '0;
						levels_q <= '0;
						state_q <= ST_LVL;
					end else begin
						state_q <= ST_SEED_W;
					end
				end
				ST_SEED_W: begin
					if (deg_d == '0) begin
						csize_q <= csize_q + 1'b1;
					end
					cnt_q <= cnt_q + 1'b1;
					state_q <= ST_SEED;
				end
				ST_LVL: begin
					if (csize_q == '0) begin
						state_q <= ST_FIN;
					end else if (cnt_q == csize_q) begin
						bank_q <= ~bank_q;
						csize_q <= nsize_q;
						total_q <= total_q + nsize_q;
						levels_q <= levels_q + 1'b1;
						nsize_q <= '0;
						cnt_q <= '0;
					end else begin
						state_q <= ST_LW;
					end
				end
				ST_LW: state_q <= ST_LW2;
				ST_LW2: begin
					wval_q <= val_d;
					e_q <= lo;
					hi_q <= hi;
					state_q <= ST_LE;
				end
				ST_LE: begin
					if (e_q < hi_q) begin
						state_q <= ST_LE_W;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= ST_LVL;
					end
				end
				ST_LE_W: begin
					v_q <= edge_d;
					if (v_in) begin
						state_q <= ST_LUPD;
					end else begin
						e_q <= e_q + 1'b1;
						state_q <= ST_LE;
					end
				end
				ST_LUPD: begin
					if (deg_d == DW'(1)) begin
						nsize_q <= nsize_q + 1'b1;
					end
					e_q <= e_q + 1'b1;
					state_q <= ST_LE;
				end
				ST_FIN: begin
					run_proc_q <= total_q;
					run_lvl_q <= levels_q;
					run_reached_q <= (total_q == n);
					ran_q <= 1'b1;
					s1_cmd <= '{op: dfpc_pkg::OP_RUN, index: '0, value: '0, bad: 1'b0};
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_pop_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cmd_pop)
		else $error("command taken during a run");

	a_s1_empty_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_CLR) |-> !s1_valid)
		else $error("result stage busy during a run");

	a_frontier_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(nsize_q) <= MAX_VERTICES) && (32'(csize_q) <= MAX_VERTICES))
		else $error("frontier size out of range");

	a_run_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> (s1_valid && s1_cmd.op == dfpc_pkg::OP_RUN))
		else $error("run finished without a result");

endmodule

### hw/rtl/dag_frontier_path_count.sv
// top level of the dag frontier path counter: register port, input stage, queue, engine
//
// Load items (row start, edge target) and read items are taken one per cycle while no run is
// in progress and the output is free, and give one result each. A run item first clears
// every entry of the degree and value stores, then counts in-degrees over the edges of each
// vertex (skipping edges whose target is outside the vertex count), seeds the sources, and
// walks the frontier level by level, adding each frontier vertex's path count to the targets
// of its kept edges and appending a target once its remaining in-degree reaches zero;
// every store is a registered-read memory and each edge update is a read-modify-write.
// Results of loads and reads before any run report a path count of zero.
module dag_frontier_path_count #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // index[12:0], load_value[26:13], zero fill
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // path_count[31:0], processed_count[42:32],
	                               // level_count[53:43], all_reached[54], bad_access[55]
);

	localparam int NW = $clog2(MAX_VERTICES) + 1;

	logic [dfpc_pkg::VCOUNT_W-1:0] vcount_q;
	logic [NW-1:0]                 n;
	logic                          f_valid, f_ready, q_empty, q_full, q_pop;
	dfpc_pkg::cmd_t                f_cmd, q_cmd;
	logic [dfpc_pkg::PATH_W-1:0]   path_count;
	logic [dfpc_pkg::TOTAL_W-1:0]  processed_count, level_count;
	logic                          all_reached, bad_access;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? 32'(vcount_q) : '0;
	assign n = (32'(vcount_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcount_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= dfpc_pkg::VCOUNT_W'(1);
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			vcount_q <= pwdata[dfpc_pkg::VCOUNT_W-1:0];
		end
	end

	dfpc_front #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES(MAX_EDGES),
		.NW(NW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.n(n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_op(dfpc_pkg::op_t'(s_tuser)),
		.in_index(s_tdata[12:0]),
		.in_value(s_tdata[26:13]),
		.cmd_valid(f_valid),
		.cmd_ready(f_ready),
		.cmd(f_cmd)
	);

	assign f_ready = !q_full;

	dfpc_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(f_valid),
		.full(q_full),
		.push_cmd(f_cmd),
		.pop(q_pop),
		.empty(q_empty),
		.pop_cmd(q_cmd)
	);

	dfpc_engine #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES(MAX_EDGES),
		.NW(NW)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.n(n),
		.cmd_valid(!q_empty),
		.cmd_pop(q_pop),
		.cmd(q_cmd),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.path_count(path_count),
		.processed_count(processed_count),
		.level_count(level_count),
		.all_reached(all_reached),
		.bad_access(bad_access)
	);

	assign m_tdata = {bad_access, all_reached, level_count, processed_count, path_count};

endmodule
